[sv/wsd_pkg.sv]
// wsd_pkg: shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parse, wsd_outreg and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  // How the payload length was encoded
  typedef enum logic [1:0] {
    LM_SHORT = 2'd0,
    LM_16    = 2'd1,
    LM_64    = 2'd2
  } len_mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result transaction
  typedef struct packed {
    kind_e       kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [62:0] frame_len;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last_in_frame;
  } result_t;

endpackage

`default_nettype wire

[sv/wsd_parse.sv]
// wsd_parse: frame header state machine and payload unmasking, one byte per cycle while accept_i is high.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 res_valid_o,
  output wsd_pkg::result_t     res_o
);

  wsd_pkg::phase_e    phase_q, phase_d;
  wsd_pkg::len_mode_e lmode_q, lmode_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] key_q, key_d;
  logic [62:0] rem_q, rem_d;
  logic [1:0]  kidx_q, kidx_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;

  logic        do_finish;
  logic [3:0]  need;
  logic [7:0]  key_byte;

  // Key byte for the current payload position, first received byte first
  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign need = (lmode_q == wsd_pkg::LM_16) ? wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    lmode_d   = lmode_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    key_d     = key_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    do_finish = 1'b0;
    res_valid_o         = 1'b0;
    res_o.kind          = wsd_pkg::KIND_HEADER;
    res_o.payload_byte  = 8'd0;
    res_o.last_in_frame = 1'b0;

    case (phase_q)
      wsd_pkg::PH_BYTE1: begin
        mask_d = data_byte_i[7];
        key_d  = 32'd0;
        acc_d  = 64'd0;
        cnt_d  = 4'd0;
        if (data_byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
          lmode_d = wsd_pkg::LM_16;
          phase_d = wsd_pkg::PH_EXTLEN;
        end else if (data_byte_i[6:0] == wsd_pkg::LEN7_EXT64) begin
          lmode_d = wsd_pkg::LM_64;
          phase_d = wsd_pkg::PH_EXTLEN;
        end else begin
          lmode_d = wsd_pkg::LM_SHORT;
          acc_d   = {57'd0, data_byte_i[6:0]};
          if (data_byte_i[7]) begin
            phase_d = wsd_pkg::PH_KEY;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        acc_d = {acc_q[55:0], data_byte_i};
        cnt_d = cnt_q + 4'd1;
        if (cnt_d >= need) begin
          if (mask_q) begin
            cnt_d   = 4'd0;
            phase_d = wsd_pkg::PH_KEY;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d = {key_q[23:0], data_byte_i};
        cnt_d = cnt_q + 4'd1;
        if (cnt_d >= wsd_pkg::KEY_BYTES) begin
          do_finish = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        // last when one byte or none was left before this one
        res_valid_o         = 1'b1;
        res_o.kind          = wsd_pkg::KIND_PAYLOAD;
        res_o.payload_byte  = mask_q ? (data_byte_i ^ key_byte) : data_byte_i;
        res_o.last_in_frame = (rem_q[62:1] == 62'd0);
        kidx_d = kidx_q + 2'd1;
        if (rem_q != 63'd0) begin
          rem_d = rem_q - 63'd1;
        end
        if (res_o.last_in_frame) begin
          phase_d = wsd_pkg::PH_BYTE0;
        end
      end
      default: begin
        fin_d    = data_byte_i[7];
        opcode_d = data_byte_i[3:0];
        phase_d  = wsd_pkg::PH_BYTE1;
      end
    endcase

    // Header complete: header result, or error on an oversized 64-bit length
    if (do_finish) begin
      res_valid_o = 1'b1;
      if (lmode_d == wsd_pkg::LM_64 && acc_d[63]) begin
        res_o.kind          = wsd_pkg::KIND_ERROR;
        res_o.last_in_frame = 1'b1;
        phase_d             = wsd_pkg::PH_BYTE0;
      end else begin
        rem_d  = acc_d[62:0];
        kidx_d = 2'd0;
        res_o.last_in_frame = (acc_d[62:0] == 63'd0);
        phase_d = res_o.last_in_frame ? wsd_pkg::PH_BYTE0 : wsd_pkg::PH_PAYLOAD;
      end
    end

    res_o.fin       = fin_d;
    res_o.opcode    = opcode_d;
    res_o.masked    = mask_d;
    res_o.frame_len = acc_d[62:0];
    res_o.mask_key  = key_d;
  end

  // State registers, updated per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_BYTE0;
      lmode_q  <= wsd_pkg::LM_SHORT;
      cnt_q    <= 4'd0;
      acc_q    <= 64'd0;
      key_q    <= 32'd0;
      rem_q    <= 63'd0;
      kidx_q   <= 2'd0;
      fin_q    <= 1'b0;
      opcode_q <= 4'd0;
      mask_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      lmode_q  <= lmode_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
    end
  end

  // Payload phase always has bytes left to take
  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsd_pkg::PH_PAYLOAD |-> rem_q != 63'd0)
    else $error("payload phase with zero bytes remaining");

  // Length errors always close the frame
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == wsd_pkg::KIND_ERROR |-> res_o.last_in_frame)
    else $error("length error not flagged last");

  // First header byte never produces a result and leads to the second
  a_byte0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == wsd_pkg::PH_BYTE0 |-> !res_valid_o ##1 phase_q == wsd_pkg::PH_BYTE1)
    else $error("first header byte handled wrongly");

endmodule

`default_nettype wire

[sv/wsd_outreg.sv]
// wsd_outreg: result register between the parser and the output channel.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_outreg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wsd_pkg::result_t      res_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output wsd_pkg::result_t      res_o
);

  logic             valid_q, valid_d;
  wsd_pkg::result_t res_q;

  // Room when empty or the held transaction leaves this cycle
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[sv/websocket_frame_deframer_unit.sv]
// websocket_frame_deframer_unit: top level, byte stream in, header/payload results out.
// Depends on wsd_pkg, wsd_parse and wsd_outreg.
//
//   Channel   Direction  Handshake                       Payload
//   data      in         data_valid_i / data_ready_o     data_byte_i
//   result    out        result_valid_o / result_ready_i result_kind_o .. last_in_frame_o
//
// One byte is taken per cycle; its result, if any, shows in the next cycle.
// Throughput is set by the single result register: one byte per clock while
// the result side takes every transaction.
// A held result stalls input only when result_ready_i is low.
// Reset (rst_ni low, asynchronous) returns the parser to the first header byte
// and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        data_valid_i,
  output logic             data_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             result_valid_o,
  input  wire logic        result_ready_i,
  output logic [1:0]       result_kind_o,
  output logic             fin_o,
  output logic [3:0]       opcode_o,
  output logic             masked_o,
  output logic [62:0]      frame_len_o,
  output logic [31:0]      mask_key_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_in_frame_o
);

  logic             accept;
  logic             res_valid;
  logic             room;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign data_ready_o = room;
  assign accept       = data_valid_i && room;

  wsd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && res_valid),
    .res_i   (res),
    .room_o  (room),
    .valid_o (result_valid_o),
    .ready_i (result_ready_i),
    .res_o   (out_res)
  );

  assign result_kind_o   = out_res.kind;
  assign fin_o           = out_res.fin;
  assign opcode_o        = out_res.opcode;
  assign masked_o        = out_res.masked;
  assign frame_len_o     = out_res.frame_len;
  assign mask_key_o      = out_res.mask_key;
  assign payload_byte_o  = out_res.payload_byte;
  assign last_in_frame_o = out_res.last_in_frame;

endmodule

`default_nettype wire

[verif/tb.sv]
// tb: self-checking testbench for websocket_frame_deframer_unit.
// Depends on wsd_pkg and the deframer RTL. It drives framed byte streams and checks
// every header, payload and length-error transaction against its own frame parser.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_AT      = 150;   // result count that starts the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 560;

  typedef struct {
    logic [7:0] b;
    bit         pause;   // wait for all outstanding results before sending this byte
  } stim_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        data_valid_i   = 1'b0;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        result_ready_i = 1'b0;
  logic        data_ready_o;
  logic        result_valid_o;
  logic [1:0]  result_kind_o;
  logic        fin_o;
  logic [3:0]  opcode_o;
  logic        masked_o;
  logic [62:0] frame_len_o;
  logic [31:0] mask_key_o;
  logic [7:0]  payload_byte_o;
  logic        last_in_frame_o;

  stim_t            byte_stream[$];
  wsd_pkg::result_t expected_results[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int frames_parsed = 0;
  int length_errors = 0;
  int masked_frames = 0;

  // Frame parser state
  wsd_pkg::phase_e    pr_phase  = wsd_pkg::PH_BYTE0;
  wsd_pkg::len_mode_e pr_mode   = wsd_pkg::LM_SHORT;
  logic [3:0]  pr_count  = '0;
  logic [63:0] pr_len    = '0;
  logic [31:0] pr_key    = '0;
  logic [62:0] pr_left   = '0;
  logic [1:0]  pr_kidx   = '0;
  logic        pr_fin    = 1'b0;
  logic [3:0]  pr_opcode = '0;
  logic        pr_masked = 1'b0;

  // Idle control
  int tx_gap     = 0;
  int rx_stall   = 0;
  int rx_hold    = 0;
  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;
  bit rx_holding = 1'b0;

  websocket_frame_deframer_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, occasionally a long one
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void emit(wsd_pkg::kind_e kind, logic [7:0] pbyte, logic last);
    wsd_pkg::result_t r;
    r.kind          = kind;
    r.fin           = pr_fin;
    r.opcode        = pr_opcode;
    r.masked        = pr_masked;
    r.frame_len     = pr_len[62:0];
    r.mask_key      = pr_key;
    r.payload_byte  = pbyte;
    r.last_in_frame = last;
    expected_results.push_back(r);
  endfunction

  // Header done: oversized 64-bit length is an error, else header (last if empty)
  function automatic void close_header();
    frames_parsed++;
    if (pr_masked) masked_frames++;
    if (pr_mode == wsd_pkg::LM_64 && pr_len[63]) begin
      length_errors++;
      emit(wsd_pkg::KIND_ERROR, 8'h00, 1'b1);
      pr_phase = wsd_pkg::PH_BYTE0;
    end else begin
      pr_left = pr_len[62:0];
      pr_kidx = '0;
      if (pr_left == '0) begin
        emit(wsd_pkg::KIND_HEADER, 8'h00, 1'b1);
        pr_phase = wsd_pkg::PH_BYTE0;
      end else begin
        emit(wsd_pkg::KIND_HEADER, 8'h00, 1'b0);
        pr_phase = wsd_pkg::PH_PAYLOAD;
      end
    end
  endfunction

  function automatic void length_done();
    if (pr_masked) begin
      pr_count = '0;
      pr_phase = wsd_pkg::PH_KEY;
    end else begin
      close_header();
    end
  endfunction

  // Advance the parser by one accepted byte
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] v;
    case (pr_phase)
      wsd_pkg::PH_BYTE1: begin
        pr_masked = b[7];
        pr_key    = '0;
        pr_len    = '0;
        pr_count  = '0;
        if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          pr_mode  = wsd_pkg::LM_16;
          pr_phase = wsd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
          pr_mode  = wsd_pkg::LM_64;
          pr_phase = wsd_pkg::PH_EXTLEN;
        end else begin
          pr_mode = wsd_pkg::LM_SHORT;
          pr_len  = {57'd0, b[6:0]};
          length_done();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        pr_len   = {pr_len[55:0], b};
        pr_count = pr_count + 4'd1;
        if (pr_count >= ((pr_mode == wsd_pkg::LM_16) ? wsd_pkg::EXT16_BYTES :
                         wsd_pkg::EXT64_BYTES)) length_done();
      end
      wsd_pkg::PH_KEY: begin
        pr_key   = {pr_key[23:0], b};
        pr_count = pr_count + 4'd1;
        if (pr_count >= wsd_pkg::KEY_BYTES) close_header();
      end
      wsd_pkg::PH_PAYLOAD: begin
        v = b ^ (pr_masked ? pr_key[8 * (3 - pr_kidx) +: 8] : 8'h00);
        pr_kidx = pr_kidx + 2'd1;
        if (pr_left != '0) pr_left = pr_left - 63'd1;
        emit(wsd_pkg::KIND_PAYLOAD, v, pr_left == '0);
        if (pr_left == '0) pr_phase = wsd_pkg::PH_BYTE0;
      end
      default: begin
        pr_fin    = b[7];
        pr_opcode = b[3:0];
        pr_phase  = wsd_pkg::PH_BYTE1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Serialize one frame: header bytes, optional key, then random payload
  task automatic queue_frame(input logic [7:0] b0, input logic msk,
                             input wsd_pkg::len_mode_e mode,
                             input logic [63:0] len, input logic [31:0] k, input bit pause);
    stim_t s;
    int    n_pay;
    s.pause = pause;
    s.b     = b0;
    byte_stream.push_back(s);
    s.pause = 1'b0;
    case (mode)
      wsd_pkg::LM_16: begin
        s.b = {msk, wsd_pkg::LEN7_EXT16};
        byte_stream.push_back(s);
        for (int i = 1; i >= 0; i--) begin
          s.b = len[i * 8 +: 8];
          byte_stream.push_back(s);
        end
      end
      wsd_pkg::LM_64: begin
        s.b = {msk, wsd_pkg::LEN7_EXT64};
        byte_stream.push_back(s);
        for (int i = 7; i >= 0; i--) begin
          s.b = len[i * 8 +: 8];
          byte_stream.push_back(s);
        end
      end
      default: begin
        s.b = {msk, len[6:0]};
        byte_stream.push_back(s);
      end
    endcase
    if (msk) begin
      for (int i = 3; i >= 0; i--) begin
        s.b = k[i * 8 +: 8];
        byte_stream.push_back(s);
      end
    end
    n_pay = (mode == wsd_pkg::LM_64 && len[63]) ? 0 : int'(len[31:0]);
    for (int i = 0; i < n_pay; i++) begin
      s.b = 8'($urandom_range(0, 255));
      byte_stream.push_back(s);
    end
  endtask

  // Driver: offers queued bytes, predicts each accepted transaction
  always @(posedge clk_i) begin : drive_proc
    logic nxt_valid;
    stim_t nxt_item;
    nxt_valid = data_valid_i;
    if (rst_ni) begin
      if (data_valid_i && data_ready_o) begin
        deframe_byte(data_byte_i);
        bytes_sent++;
        tx_gap    = tx_calm ? 0 : pick_gap();
        nxt_valid = 1'b0;
        if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
      end
      if (rx_holding) tx_gap = 0;   // keep pushing while the receiver holds off
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_stream.size() > 0 &&
                     !(byte_stream[0].pause && expected_results.size() > 0)) begin
          nxt_item = byte_stream.pop_front();
          data_byte_i <= nxt_item.b;
          nxt_valid = 1'b1;
        end
      end
      data_valid_i <= nxt_valid;
    end
  end

  // Monitor: checks each result transaction and drives ready with random stalls
  always @(posedge clk_i) begin : monitor_proc
    logic             nxt_ready;
    wsd_pkg::result_t want;
    nxt_ready = result_ready_i;
    if (rst_ni) begin
      if (result_valid_o && result_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d", result_kind_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("fin", want.fin, fin_o);
          check_field("opcode", want.opcode, opcode_o);
          check_field("masked", want.masked, masked_o);
          check_field("frame_len", want.frame_len, frame_len_o);
          check_field("mask_key", want.mask_key, mask_key_o);
          check_field("payload_byte", want.payload_byte, payload_byte_o);
          check_field("last_in_frame", want.last_in_frame, last_in_frame_o);
        end
        if (results_seen == HOLD_AT) rx_hold = HOLD_CYCLES;
        else rx_stall = rx_calm ? 0 : pick_gap();
        if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nxt_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      result_ready_i <= nxt_ready;
      rx_holding     <= (rx_hold > 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int          target;
    int          sel;
    logic [7:0]  b0;
    logic        msk;
    logic [31:0] k;
    bit          pause;

    // Directed: special frame shapes
    queue_frame(8'h89, 1'b0, wsd_pkg::LM_SHORT, 64'd0, 32'h0, 1'b0);          // empty ping
    queue_frame(8'h81, 1'b1, wsd_pkg::LM_SHORT, 64'd5, 32'h37FA_213D, 1'b0);
    queue_frame(8'h02, 1'b1, wsd_pkg::LM_SHORT, 64'd0, 32'hFFFF_FFFF, 1'b0);  // masked, empty
    queue_frame(8'h00, 1'b0, wsd_pkg::LM_SHORT, 64'd125, 32'h0, 1'b0);  // longest short form
    queue_frame(8'hFF, 1'b1, wsd_pkg::LM_SHORT, 64'd3, 32'h0, 1'b0);          // zero key
    queue_frame(8'h82, 1'b0, wsd_pkg::LM_16, 64'd0, 32'h0, 1'b0);          // non-minimal empty
    queue_frame(8'h01, 1'b1, wsd_pkg::LM_16, 64'd126, 32'hA5A5_5A5A, 1'b0);
    queue_frame(8'h88, 1'b1, wsd_pkg::LM_64, 64'd0, 32'h0102_0304, 1'b0);
    queue_frame(8'h8A, 1'b0, wsd_pkg::LM_64, 64'd7, 32'h0, 1'b0);
    // Oversized 64-bit lengths
    queue_frame(8'h81, 1'b0, wsd_pkg::LM_64, 64'h8000_0000_0000_0000, 32'h0, 1'b0);
    queue_frame(8'h7F, 1'b1, wsd_pkg::LM_64, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // Every opcode, with mixed flag and reserved bits
    for (int op = 0; op < 16; op++) begin
      queue_frame({~op[0], 3'(op), 4'(op)}, op[1], wsd_pkg::LM_SHORT, 64'(op % 4),
                  32'hC0DE_0000 | op, op == 15);
    end

    // Random frames
    target = byte_stream.size() + RANDOM_BYTES;
    while (byte_stream.size() < target) begin
      b0    = 8'($urandom_range(0, 255));
      msk   = 1'($urandom_range(0, 1));
      k     = $urandom;
      sel   = $urandom_range(0, 9);
      if (sel == 0) k = '0;
      if (sel == 1) k = '1;
      pause = ($urandom_range(0, 49) == 0);
      sel   = $urandom_range(0, 99);
      if (sel < 55) begin
        queue_frame(b0, msk, wsd_pkg::LM_SHORT, ($urandom_range(0, 9) == 0) ?
                    $urandom_range(0, 125) : $urandom_range(0, 16), k, pause);
      end else if (sel < 72) begin
        queue_frame(b0, msk, wsd_pkg::LM_16, ($urandom_range(0, 9) == 0) ?
                    $urandom_range(126, 300) : $urandom_range(0, 24), k, pause);
      end else if (sel < 86) begin
        queue_frame(b0, msk, wsd_pkg::LM_64, $urandom_range(0, 24), k, pause);
      end else begin
        queue_frame(b0, msk, wsd_pkg::LM_64, {1'b1, 31'($urandom), 32'($urandom)}, k, pause);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until everything is sent and answered, then let the pipeline settle
    while (byte_stream.size() != 0 || data_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames (%0d masked, %0d length errors).",
             bytes_sent, frames_parsed, masked_frames, length_errors);
    $display("Checked %0d result transactions in %0d cycles.", results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
